// File: rtl/core/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define KNN_ASSERT_SAME(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define KNN_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: rtl/core/knn_pkg.sv
package knn_pkg;

    // Distance arithmetic
    localparam int DIST_BITS = 38;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    // Register and field widths
    localparam int NCOUNT_BITS = 5;
    localparam int MASK_BITS   = 16;
    localparam int USED_BITS   = 5;

    // Input item kinds (tuser)
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_TRAIN = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_ANSWERED = 2'd0;
    localparam logic [1:0] STAT_STORED   = 2'd1;
    localparam logic [1:0] STAT_DROPPED  = 2'd2;

    // Register select (paddr[2])
    localparam logic REG_NCOUNT = 1'b0;
    localparam logic REG_FMASK  = 1'b1;

    // One neighbor slot / one distance candidate
    typedef struct packed {
        logic                 valid;
        logic [DIST_BITS-1:0] distance;
        logic                 label;
    } t_entry;

    // Control tags riding along the distance pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic enable;
        logic label;
    } t_tag;

    // Result item, packed in tdata order (class in bit 0)
    typedef struct packed {
        logic [USED_BITS-1:0] used;
        logic [1:0]           status;
        logic                 cls;
    } t_result;

    // Strict (distance, label) order: ties go to label 0
    function automatic logic entry_less(t_entry a, t_entry b);
        return (a.distance < b.distance) ||
               ((a.distance == b.distance) && (a.label < b.label));
    endfunction

endpackage

// File: rtl/core/knn_ram.sv
module knn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/knn_cell.sv
module knn_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_clear,
    input  logic           i_active,
    input  knn_pkg::t_entry i_cand,
    input  knn_pkg::t_entry i_prev,
    input  logic           i_prev_take,
    output knn_pkg::t_entry o_entry,
    output logic           o_take
);
    import knn_pkg::*;

    t_entry r_entry;

    // Candidate belongs at or above this slot
    assign o_take = i_active && (!r_entry.valid || entry_less(i_cand, r_entry));

    // Insert: the first taking slot gets the candidate, later ones shift down
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else if (i_clear) begin
            r_entry.valid <= 1'b0;
        end else if (i_cand.valid && o_take) begin
            r_entry <= i_prev_take ? i_prev : i_cand;
        end
    end

    assign o_entry = r_entry;

endmodule

// File: rtl/core/knn_dist.sv
module knn_dist #(
    parameter int FEATURE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  knn_pkg::t_tag           i_tag,
    input  logic [FEATURE_BITS-1:0] i_query,
    input  logic [FEATURE_BITS-1:0] i_sample,
    output knn_pkg::t_entry         o_cand,
    output logic                    o_busy
);
    import knn_pkg::*;

    localparam int DW = FEATURE_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int XW = (PW > DIST_BITS) ? PW : DIST_BITS;

    t_tag                 r_tag2;
    t_tag                 r_tag3;
    logic [DW-1:0]        r_ad2;
    logic [DIST_BITS-1:0] r_sq3;
    logic [DIST_BITS-1:0] r_acc;
    t_entry               r_cand;

    logic signed [DW-1:0] diff;
    logic [DW-1:0]        ad;
    logic [PW-1:0]        prod;
    logic [XW-1:0]        prod_x;
    logic [DIST_BITS-1:0] sq;
    logic [DIST_BITS:0]   sum;
    logic [DIST_BITS-1:0] sum_sat;

    // Stage 2: absolute difference of sign-extended features
    assign diff = $signed({i_query[FEATURE_BITS-1], i_query})
                - $signed({i_sample[FEATURE_BITS-1], i_sample});
    assign ad   = diff[DW-1] ? DW'(-diff) : DW'(diff);

    // Stage 3: square, saturate, drop masked features
    assign prod   = PW'(r_ad2) * PW'(r_ad2);
    assign prod_x = XW'(prod);
    always_comb begin
        if (!r_tag2.enable) begin
            sq = '0;
        end else if (prod_x > XW'(DIST_MAX)) begin
            sq = DIST_MAX;
        end else begin
            sq = prod_x[DIST_BITS-1:0];
        end
    end

    // Stage 4: saturating running sum per sample
    assign sum     = {1'b0, (r_tag3.first ? {DIST_BITS{1'b0}} : r_acc)} + {1'b0, r_sq3};
    assign sum_sat = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag2.valid <= 1'b0;
            r_tag3.valid <= 1'b0;
            r_cand.valid <= 1'b0;
        end else begin
            r_tag2       <= i_tag;
            r_tag3       <= r_tag2;
            r_cand.valid <= r_tag3.valid && r_tag3.last;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_ad2 <= ad;
        r_sq3 <= sq;
        if (r_tag3.valid) begin
            r_acc           <= sum_sat;
            r_cand.distance <= sum_sat;
            r_cand.label    <= r_tag3.label;
        end
    end

    assign o_cand = r_cand;
    assign o_busy = r_tag2.valid || r_tag3.valid || r_cand.valid;

endmodule

// File: rtl/core/knn_binary_classifier_core.sv
// Channel      | Dir | Handshake            | Payload
// s_axis       | in  | tvalid/tready        | tdata: feature_value, sample_label; tuser: kind;
//              |     |                      | tlast: last_element
// m_axis       | out | tvalid/tready        | tdata: predicted_class, status, neighbors_used
// apb          | in  | psel/penable/pready  | 0x0 neighbor_count, 0x4 feature_mask
//
// Training and query elements load one per cycle while input is not stalled. After the last
// query element the walk reads the sample store in order, one read per cycle through its
// single read port, then the pipeline drains and the vote is taken.
// Reset is synchronous and clears control state; the sample and label stores are
// not cleared and need no clearing pass. Input is stalled during the walk, drain
// and vote, and while two results wait on the output side.
`include "assert_macros.svh"

module knn_binary_classifier_core #(
    parameter int NUM_FEATURES = 16,
    parameter int MAX_SAMPLES  = 256,
    parameter int MAX_K        = 16,
    parameter int FEATURE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // stream in
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [FEATURE_BITS-1:0] feature_value, [FEATURE_BITS] sample_label, rest zero
    input  logic [((FEATURE_BITS+8)/8)*8-1:0]   i_s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]                          i_s_axis_tuser,
    input  logic                                i_s_axis_tlast,
    // stream out
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [0] predicted_class, [2:1] status, [7:3] neighbors_used
    output logic [7:0]                          o_m_axis_tdata,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import knn_pkg::*;

    localparam int FW    = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int PSW   = $clog2(NUM_FEATURES + 1);
    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int SW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int DEPTH = MAX_SAMPLES * NUM_FEATURES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW    = $clog2(DEPTH + 1);
    localparam int KCW   = $clog2(MAX_K + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_VOTE  = 2'd3;

    // Configuration registers
    logic [NCOUNT_BITS-1:0] r_ncount;
    logic [MASK_BITS-1:0]   r_fmask;
    logic                   cfg_we;

    // Control state
    logic [1:0]             r_state;
    logic [PSW-1:0]         r_pos;
    logic [CW-1:0]          r_count;
    logic [BW-1:0]          r_wr_base;
    logic [CW-1:0]          r_s;
    logic [FW-1:0]          r_f;
    logic [AW-1:0]          r_rd_addr;
    logic [FEATURE_BITS-1:0] r_qbuf [NUM_FEATURES];

    // Stage 1 tags and query operand
    t_tag                    r_tag1;
    logic [FEATURE_BITS-1:0] r_q1;
    t_tag                    st1;

    // Output queue: head and skid
    t_result r_out;
    t_result r_skid;
    logic    r_ov;
    logic    r_sv;
    t_result push_data;
    logic    push;
    logic    pop;

    // Input decode
    logic                    in_acc;
    logic [1:0]              in_kind;
    logic [FEATURE_BITS-1:0] in_fval;
    logic                    in_label;
    logic                    in_last;
    logic                    train_acc;
    logic                    query_acc;
    logic                    room;
    logic                    pos_ok;

    // Memories
    logic                    smp_we;
    logic [AW-1:0]           smp_waddr;
    logic [FEATURE_BITS-1:0] smp_rdata;
    logic                    lab_we;
    logic                    lab_rdata;

    // Feature enables, distance, cells, vote
    logic [NUM_FEATURES-1:0] fen;
    t_entry                  cand;
    logic                    dist_busy;
    logic [NCOUNT_BITS-1:0]  k_eff;
    logic                    cell_clear;
    t_entry                  cell_q    [MAX_K];
    logic [MAX_K-1:0]        cell_take;
    logic [MAX_K-1:0]        cell_valid;
    logic [KCW-1:0]          used_cnt;
    logic [KCW-1:0]          c0_cnt;
    logic                    vote_cls;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncount <= NCOUNT_BITS'(1);
            r_fmask  <= '1;
        end else if (cfg_we) begin
            if (paddr[2] == REG_FMASK) begin
                r_fmask <= pwdata[MASK_BITS-1:0];
            end else begin
                r_ncount <= pwdata[NCOUNT_BITS-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_FMASK) ? {{(32-MASK_BITS){1'b0}}, r_fmask}
                                            : {{(32-NCOUNT_BITS){1'b0}}, r_ncount};

    // ---------------- input decode ----------------
    assign o_s_axis_tready = (r_state == ST_IDLE) && !r_sv;
    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign in_kind   = i_s_axis_tuser;
    assign in_fval   = i_s_axis_tdata[FEATURE_BITS-1:0];
    assign in_label  = i_s_axis_tdata[FEATURE_BITS];
    assign in_last   = i_s_axis_tlast;
    assign train_acc = in_acc && (in_kind == KIND_TRAIN);
    assign query_acc = in_acc && (in_kind == KIND_QUERY);
    assign room      = r_count < CW'(MAX_SAMPLES);
    assign pos_ok    = r_pos < PSW'(NUM_FEATURES);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pos     <= '0;
            r_count   <= '0;
            r_wr_base <= '0;
            r_s       <= '0;
            r_f       <= '0;
            r_rd_addr <= '0;
            for (int i = 0; i < NUM_FEATURES; i++) begin
                r_qbuf[i] <= '0;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        unique case (in_kind)
                            KIND_CLEAR: begin
                                r_count   <= '0;
                                r_pos     <= '0;
                                r_wr_base <= '0;
                            end
                            KIND_TRAIN: begin
                                if (in_last) begin
                                    r_pos <= '0;
                                    if (room) begin
                                        r_count   <= r_count + 1'b1;
                                        r_wr_base <= r_wr_base + BW'(NUM_FEATURES);
                                    end
                                end else if (pos_ok) begin
                                    r_pos <= r_pos + 1'b1;
                                end
                            end
                            KIND_QUERY: begin
                                if (pos_ok) begin
                                    r_qbuf[r_pos[FW-1:0]] <= in_fval;
                                end
                                if (in_last) begin
                                    r_pos     <= '0;
                                    r_s       <= '0;
                                    r_f       <= '0;
                                    r_rd_addr <= '0;
                                    r_state   <= (r_count == '0) ? ST_VOTE : ST_WALK;
                                end else if (pos_ok) begin
                                    r_pos <= r_pos + 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_WALK: begin
                    // one sample-store read per cycle, samples in order
                    r_rd_addr <= r_rd_addr + 1'b1;
                    if (r_f == FW'(NUM_FEATURES - 1)) begin
                        r_f <= '0;
                        r_s <= r_s + 1'b1;
                        if (CW'(r_s + 1'b1) == r_count) begin
                            r_state <= ST_DRAIN;
                        end
                    end else begin
                        r_f <= r_f + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (!r_tag1.valid && !dist_busy) begin
                        r_state <= ST_VOTE;
                    end
                end
                ST_VOTE: begin
                    if (!r_sv) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ---------------- stores ----------------
    assign smp_we    = train_acc && room && pos_ok;
    assign smp_waddr = AW'(r_wr_base + BW'(r_pos));
    assign lab_we    = train_acc && in_last && room;

    knn_ram #(
        .WIDTH (FEATURE_BITS),
        .DEPTH (DEPTH)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (smp_we),
        .i_waddr (smp_waddr),
        .i_wdata (in_fval),
        .i_raddr (r_rd_addr),
        .o_rdata (smp_rdata)
    );

    knn_ram #(
        .WIDTH (1),
        .DEPTH (MAX_SAMPLES)
    ) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (lab_we),
        .i_waddr (r_count[SW-1:0]),
        .i_wdata (in_label),
        .i_raddr (r_s[SW-1:0]),
        .o_rdata (lab_rdata)
    );

    // ---------------- feature enables ----------------
    for (genvar g = 0; g < NUM_FEATURES; g++) begin : g_fen
        if (g < MASK_BITS) begin : g_masked
            assign fen[g] = r_fmask[g];
        end else begin : g_always
            assign fen[g] = 1'b1;
        end
    end

    // ---------------- stage 1: aligned with RAM read data ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.valid <= 1'b0;
        end else begin
            r_tag1.valid <= (r_state == ST_WALK);
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag1.first  <= (r_f == '0);
        r_tag1.last   <= (r_f == FW'(NUM_FEATURES - 1));
        r_tag1.enable <= fen[r_f];
        r_tag1.label  <= 1'b0;
        r_q1          <= r_qbuf[r_f];
    end

    always_comb begin
        st1       = r_tag1;
        st1.label = lab_rdata;
    end

    knn_dist #(
        .FEATURE_BITS (FEATURE_BITS)
    ) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (st1),
        .i_query  (r_q1),
        .i_sample (smp_rdata),
        .o_cand   (cand),
        .o_busy   (dist_busy)
    );

    // ---------------- chain of neighbor cells ----------------
    assign k_eff      = (int'(r_ncount) > MAX_K) ? NCOUNT_BITS'(MAX_K) : r_ncount;
    assign cell_clear = query_acc && in_last;

    for (genvar g = 0; g < MAX_K; g++) begin : g_cell
        t_entry prev;
        logic   prev_take;
        if (g == 0) begin : g_head
            assign prev      = '0;
            assign prev_take = 1'b0;
        end else begin : g_link
            assign prev      = cell_q[g-1];
            assign prev_take = cell_take[g-1];
        end

        knn_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_clear     (cell_clear),
            .i_active    (int'(k_eff) > g),
            .i_cand      (cand),
            .i_prev      (prev),
            .i_prev_take (prev_take),
            .o_entry     (cell_q[g]),
            .o_take      (cell_take[g])
        );

        assign cell_valid[g] = cell_q[g].valid;
    end

    // ---------------- vote ----------------
    always_comb begin
        used_cnt = '0;
        c0_cnt   = '0;
        for (int i = 0; i < MAX_K; i++) begin
            used_cnt = used_cnt + KCW'(cell_q[i].valid);
            c0_cnt   = c0_cnt + KCW'(cell_q[i].valid && !cell_q[i].label);
        end
    end

    // class 0 when label-0 votes are more than half of the effective neighbor count
    assign vote_cls = (2 * int'(c0_cnt) > int'(k_eff)) ? 1'b0 : 1'b1;

    // ---------------- result queue ----------------
    always_comb begin
        if (r_state == ST_VOTE) begin
            push_data.cls    = vote_cls;
            push_data.status = STAT_ANSWERED;
            push_data.used   = USED_BITS'(used_cnt);
        end else begin
            push_data.cls    = 1'b0;
            push_data.status = room ? STAT_STORED : STAT_DROPPED;
            push_data.used   = '0;
        end
    end

    assign push = ((r_state == ST_VOTE) && !r_sv) || (train_acc && in_last);
    assign pop  = r_ov && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (pop) begin
            if (r_sv) begin
                r_out <= r_skid;
                if (push) begin
                    r_skid <= push_data;
                end else begin
                    r_sv <= 1'b0;
                end
            end else if (push) begin
                r_out <= push_data;
            end else begin
                r_ov <= 1'b0;
            end
        end else if (push) begin
            if (!r_ov) begin
                r_out <= push_data;
                r_ov  <= 1'b1;
            end else begin
                r_skid <= push_data;
                r_sv   <= 1'b1;
            end
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_out;

    // ---------------- assertions ----------------
    `KNN_ASSERT_SAME(a_skid_has_head, i_clk, i_rst_n, r_sv, r_ov, "skid without head")
    `KNN_ASSERT_SAME(a_walk_nonempty, i_clk, i_rst_n, r_state == ST_WALK, r_count != '0, "empty walk")
    `KNN_ASSERT_SAME(a_cells_prefix, i_clk, i_rst_n, 1'b1, (cell_valid & (cell_valid + 1'b1)) == '0, "cell gap")
    `KNN_ASSERT_NEXT(a_query_starts, i_clk, i_rst_n, query_acc && in_last, r_state == ST_WALK || r_state == ST_VOTE, "no walk")

endmodule

// File: dv/tb_knn_binary_classifier_core.sv
`timescale 1ns / 1ps

module tb_knn_binary_classifier_core;
    import knn_pkg::*;

    localparam int NUM_FEATURES = 16;
    localparam int MAX_SAMPLES  = 256;
    localparam int MAX_K        = 16;
    localparam int FEATURE_BITS = 16;
    localparam int TDATA_W      = ((FEATURE_BITS + 8) / 8) * 8;

    // kind code the block must ignore
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [2:0] ADDR_NCOUNT = {REG_NCOUNT, 2'b00};
    localparam logic [2:0] ADDR_FMASK  = {REG_FMASK, 2'b00};

    // limits sized for the worst walk over MAX_SAMPLES * NUM_FEATURES entries, plus stalls
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_ITEMS   = 175;
    localparam int TAIL_ITEMS    = 200;
    localparam int LONG_HOLD     = 300;

    typedef struct {
        logic [1:0]              kind;
        logic [FEATURE_BITS-1:0] value;
        logic                    label;
        logic                    last;
    } t_element;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata;   // [15:0] feature_value, [16] sample_label, rest zero
    logic [1:0]          s_tuser;   // [1:0] kind
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [7:0]          m_tdata;   // [0] predicted_class, [2:1] status, [7:3] neighbors_used
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    knn_binary_classifier_core #(
        .NUM_FEATURES (NUM_FEATURES),
        .MAX_SAMPLES  (MAX_SAMPLES),
        .MAX_K        (MAX_K),
        .FEATURE_BITS (FEATURE_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Classifier shadow state
    logic [FEATURE_BITS-1:0] sample_mem  [MAX_SAMPLES*NUM_FEATURES];
    bit                      written_mem [MAX_SAMPLES*NUM_FEATURES];
    logic                    label_mem   [MAX_SAMPLES];
    logic [FEATURE_BITS-1:0] query_vec   [NUM_FEATURES];
    int unsigned             n_stored;
    int unsigned             elem_pos;
    logic [NCOUNT_BITS-1:0]  k_setting;
    logic [MASK_BITS-1:0]    mask_setting;
    t_result                 pending_answers[$];

    // Run bookkeeping
    int unsigned items_sent;
    int unsigned errors;
    int unsigned phases;
    int unsigned n_answered;
    int unsigned n_kept;
    int unsigned n_dropped;
    int unsigned quiet_cycles;
    int unsigned rx_hold;
    int unsigned rx_gap;
    bit          sender_idle;
    bit          receiver_idle;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Distance of stored sample s to the query over enabled features
    function automatic logic [DIST_BITS-1:0] masked_sq_distance(int unsigned s);
        longint unsigned acc;
        longint unsigned mag;
        longint unsigned sq;
        longint          diff;
        acc = 0;
        for (int f = 0; f < NUM_FEATURES; f++) begin
            if (f < MASK_BITS && !mask_setting[f])
                continue;
            diff = longint'($signed(query_vec[f]))
                 - longint'($signed(sample_mem[s*NUM_FEATURES+f]));
            mag = (diff < 0) ? -diff : diff;
            sq  = (mag > 64'hFFFF_FFFF) ? DIST_MAX : mag * mag;
            if (sq > DIST_MAX)
                sq = DIST_MAX;
            acc += sq;
            if (acc > DIST_MAX)
                acc = DIST_MAX;
        end
        return acc[DIST_BITS-1:0];
    endfunction

    // K-best selection over the store, then majority vote
    function automatic t_result vote_nearest();
        logic [DIST_BITS-1:0] best_d [MAX_K];
        logic                 best_l [MAX_K];
        logic [DIST_BITS-1:0] d;
        int unsigned          k;
        int unsigned          used;
        int unsigned          pos;
        int unsigned          j;
        int unsigned          c0;
        t_result              r;
        k    = (k_setting > MAX_K) ? MAX_K : k_setting;
        used = 0;
        for (int i = 0; i < MAX_K; i++) begin
            best_d[i] = DIST_MAX;
            best_l[i] = 1'b0;
        end
        for (int s = 0; s < n_stored && s < MAX_SAMPLES; s++) begin
            if (k == 0)
                break;
            d   = masked_sq_distance(s);
            pos = used;
            while (pos > 0 && (best_d[pos-1] > d ||
                   (best_d[pos-1] == d && best_l[pos-1] > label_mem[s])))
                pos--;
            if (pos >= k)
                continue;
            j = (used < k) ? used : k - 1;
            while (j > pos) begin
                best_d[j] = best_d[j-1];
                best_l[j] = best_l[j-1];
                j--;
            end
            best_d[pos] = d;
            best_l[pos] = label_mem[s];
            if (used < k)
                used++;
        end
        c0 = 0;
        for (int i = 0; i < used; i++)
            if (best_l[i] == 1'b0)
                c0++;
        r.cls    = (c0 > k - c0) ? 1'b0 : 1'b1;
        r.status = STAT_ANSWERED;
        r.used   = used[USED_BITS-1:0];
        return r;
    endfunction

    // Advance shadow state by one accepted transaction
    function automatic void predict_knn_step(t_element e);
        t_result r;
        bit      room;
        case (e.kind)
            KIND_CLEAR: begin
                n_stored = 0;
                elem_pos = 0;
            end
            KIND_TRAIN: begin
                room = (n_stored < MAX_SAMPLES);
                if (room && elem_pos < NUM_FEATURES) begin
                    sample_mem[n_stored*NUM_FEATURES+elem_pos]  = e.value;
                    written_mem[n_stored*NUM_FEATURES+elem_pos] = 1'b1;
                end
                if (elem_pos < NUM_FEATURES)
                    elem_pos++;
                if (e.last) begin
                    elem_pos = 0;
                    r.cls    = 1'b0;
                    r.used   = '0;
                    if (room) begin
                        label_mem[n_stored] = e.label;
                        n_stored++;
                        r.status = STAT_STORED;
                        n_kept++;
                    end else begin
                        r.status = STAT_DROPPED;
                        n_dropped++;
                    end
                    pending_answers.push_back(r);
                end
            end
            KIND_QUERY: begin
                if (elem_pos < NUM_FEATURES) begin
                    query_vec[elem_pos] = e.value;
                    elem_pos++;
                end
                if (e.last) begin
                    elem_pos = 0;
                    pending_answers.push_back(vote_nearest());
                    n_answered++;
                end
            end
            default: ;
        endcase
    endfunction

    // A slot is safe to read only once every feature has been written
    function automatic bit slot_complete(int unsigned s);
        for (int f = 0; f < NUM_FEATURES; f++)
            if (!written_mem[s*NUM_FEATURES+f])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit store_readable();
        for (int s = 0; s < n_stored && s < MAX_SAMPLES; s++)
            if (!slot_complete(s))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_element mk_element(logic [1:0] kind, logic [FEATURE_BITS-1:0] value,
                                            logic label, logic last);
        t_element e;
        e.kind  = kind;
        e.value = value;
        e.label = label;
        e.last  = last;
        return e;
    endfunction

    // 0,1: any value; 2: tight cluster around zero; 3: rails; 4: any value
    function automatic logic [FEATURE_BITS-1:0] pick_value(int unsigned style);
        logic [FEATURE_BITS-1:0] v;
        case (style)
            2: begin
                v = FEATURE_BITS'($urandom_range(0, 3));
                v = v - FEATURE_BITS'(2);
            end
            3: v = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            default: v = FEATURE_BITS'($urandom());
        endcase
        return v;
    endfunction

    function automatic void append_vector(ref t_element vec[$], input logic [1:0] kind,
                                          input int unsigned len, input logic lbl,
                                          input int unsigned style);
        for (int i = 0; i < len; i++)
            vec.push_back(mk_element(kind, pick_value(style),
                                     (i == len - 1) ? lbl : 1'($urandom_range(0, 1)),
                                     i == len - 1));
    endfunction

    // Drive one transaction; inputs move on the falling edge
    task automatic send_element(input t_element e);
        @(negedge i_clk);
        if (sender_idle && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W-FEATURE_BITS-1){1'b0}}, e.label, e.value};
        s_tuser  <= e.kind;
        s_tlast  <= e.last;
        do @(posedge i_clk); while (!s_tready);
        predict_knn_step(e);
        if (e.kind != KIND_UNUSED)
            items_sent++;
    endtask

    task automatic send_vector(input t_element vec[$]);
        foreach (vec[i])
            send_element(vec[i]);
    endtask

    task automatic stop_input();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
    endtask

    // Hold input until all results are back and the block has settled
    task automatic wait_drained();
        stop_input();
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_NCOUNT)
            k_setting = data[NCOUNT_BITS-1:0];
        else
            mask_setting = data[MASK_BITS-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [NCOUNT_BITS-1:0] k, input logic [MASK_BITS-1:0] mask);
        wait_drained();
        write_reg(ADDR_NCOUNT, 32'(k));
        write_reg(ADDR_FMASK, 32'(mask));
        phases++;
    endtask

    // One random vector: mostly well-formed training and queries, some noise
    task automatic send_random_vector();
        t_element    vec[$];
        int unsigned pick;
        int unsigned len;
        int unsigned style;
        logic [1:0]  kind;
        logic        lbl;
        pick  = $urandom_range(0, 99);
        style = $urandom_range(0, 4);
        lbl   = 1'($urandom_range(0, 1));
        if (pick < 3) begin
            vec.push_back(mk_element(KIND_CLEAR, pick_value(style), lbl,
                                     1'($urandom_range(0, 1))));
        end else if (pick < 6) begin
            repeat ($urandom_range(1, 3))
                vec.push_back(mk_element(KIND_UNUSED, pick_value(0),
                                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        end else if (pick < 10) begin
            // vector abandoned midway by a clear
            kind = $urandom_range(0, 1) ? KIND_TRAIN : KIND_QUERY;
            repeat ($urandom_range(1, 8))
                vec.push_back(mk_element(kind, pick_value(style), 1'($urandom_range(0, 1)), 1'b0));
            vec.push_back(mk_element(KIND_CLEAR, pick_value(0), lbl, 1'b0));
        end else if (pick < 14) begin
            // training and query elements share one position counter
            if (!store_readable())
                vec.push_back(mk_element(KIND_CLEAR, pick_value(0), lbl, 1'b1));
            len = $urandom_range(1, NUM_FEATURES + 2);
            for (int i = 0; i < len; i++) begin
                kind = $urandom_range(0, 1) ? KIND_TRAIN : KIND_QUERY;
                vec.push_back(mk_element(kind, pick_value(style), 1'($urandom_range(0, 1)),
                                         i == len - 1));
            end
        end else if (pick < 45) begin
            if (!store_readable())
                vec.push_back(mk_element(KIND_CLEAR, pick_value(0), lbl, 1'b1));
            len = ($urandom_range(0, 4) != 0) ? NUM_FEATURES : $urandom_range(1, NUM_FEATURES + 4);
            append_vector(vec, KIND_QUERY, len, lbl, style);
        end else begin
            // short vectors only where the slot already holds a full sample
            if (n_stored >= MAX_SAMPLES || slot_complete(n_stored))
                len = $urandom_range(1, NUM_FEATURES + 4);
            else
                len = $urandom_range(NUM_FEATURES, NUM_FEATURES + 4);
            append_vector(vec, KIND_TRAIN, len, lbl, style);
        end
        send_vector(vec);
    endtask

    // Empty store, ignored kind, overlong training vector, short query, clear
    task automatic test_directed();
        t_element vec[$];
        vec.push_back(mk_element(KIND_QUERY, 16'h7FFF, 1'b1, 1'b1));
        vec.push_back(mk_element(KIND_UNUSED, 16'hFFFF, 1'b1, 1'b1));
        for (int i = 0; i <= NUM_FEATURES; i++)
            vec.push_back(mk_element(KIND_TRAIN, (i % 2) ? 16'h8000 : 16'h7FFF, 1'b1,
                                     i == NUM_FEATURES));
        vec.push_back(mk_element(KIND_QUERY, 16'h8000, 1'b0, 1'b0));
        vec.push_back(mk_element(KIND_QUERY, 16'h7FFF, 1'b0, 1'b0));
        vec.push_back(mk_element(KIND_QUERY, 16'h0000, 1'b0, 1'b1));
        vec.push_back(mk_element(KIND_CLEAR, 16'h0000, 1'b0, 1'b0));
        vec.push_back(mk_element(KIND_QUERY, 16'h8000, 1'b0, 1'b1));
        send_vector(vec);
    endtask

    // Fill to capacity with one-element samples, overflow, then clear
    task automatic test_store_full();
        t_element vec[$];
        vec.push_back(mk_element(KIND_CLEAR, 16'h0000, 1'b0, 1'b0));
        send_vector(vec);
        while (n_stored < MAX_SAMPLES) begin
            vec.delete();
            append_vector(vec, KIND_TRAIN, 1, 1'($urandom_range(0, 1)), $urandom_range(0, 4));
            send_vector(vec);
        end
        vec.delete();
        append_vector(vec, KIND_TRAIN, 1, 1'b0, 0);
        append_vector(vec, KIND_TRAIN, 3, 1'b1, 3);
        vec.push_back(mk_element(KIND_CLEAR, 16'h0000, 1'b0, 1'b1));
        send_vector(vec);
    endtask

    // Long receiver stall so the result path fills and input backs up
    task automatic test_backpressure();
        t_element vec[$];
        vec.push_back(mk_element(KIND_CLEAR, 16'h0000, 1'b0, 1'b0));
        send_vector(vec);
        wait_drained();
        rx_hold = LONG_HOLD;
        vec.delete();
        repeat (4)
            append_vector(vec, KIND_TRAIN, NUM_FEATURES, 1'($urandom_range(0, 1)), 0);
        send_vector(vec);
        wait_drained();
    endtask

    // Random traffic across register settings, extremes included
    task automatic test_settings_sweep();
        logic [NCOUNT_BITS-1:0] k_list    [8] = '{5'd16, 5'd0, 5'd31, 5'd3,
                                                  5'd1, 5'd7, 5'd16, 5'd2};
        logic [MASK_BITS-1:0]   mask_list [8] = '{16'hFFFF, 16'h0F0F, 16'h0000, 16'h3C3C,
                                                  16'h00FF, 16'h8001, 16'h0000, 16'hA5A5};
        logic [MASK_BITS-1:0]   mask;
        int unsigned            target;
        for (int p = 0; p < 8; p++) begin
            mask = (p == 1 || p == 3 || p == 7) ? MASK_BITS'($urandom()) : mask_list[p];
            set_config(k_list[p], mask);
            sender_idle   = ($urandom_range(0, 3) != 0);
            receiver_idle = ($urandom_range(0, 3) != 0);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                send_random_vector();
        end
    endtask

    // Final stretch at full rate on both sides
    task automatic test_full_rate_tail();
        int unsigned target;
        set_config(NCOUNT_BITS'($urandom_range(1, MAX_K)), MASK_BITS'($urandom()));
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        target = items_sent + TAIL_ITEMS;
        while (items_sent < target)
            send_random_vector();
    endtask

    // Result receiver: random stall bursts plus the long hold
    always @(negedge i_clk) begin
        if (rx_hold != 0) begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else if (rx_gap != 0) begin
            m_tready <= 1'b0;
            rx_gap = rx_gap - 1;
        end else if (receiver_idle && $urandom_range(0, 11) == 0) begin
            m_tready <= 1'b0;
            rx_gap = $urandom_range(0, 9);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = t_result'(m_tdata);
            if (pending_answers.size() == 0) begin
                $error("result with nothing pending: tdata %h", m_tdata);
                errors++;
            end else begin
                want = pending_answers.pop_front();
                if (got.cls !== want.cls) begin
                    $error("predicted_class: expected %0d, got %0d", want.cls, got.cls);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
                if (got.used !== want.used) begin
                    $error("neighbors_used: expected %0d, got %0d", want.used, got.used);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = KIND_CLEAR;
        s_tlast       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        m_tready      = 1'b0;
        i_rst_n       = 1'b0;
        n_stored      = 0;
        elem_pos      = 0;
        k_setting     = NCOUNT_BITS'(1);
        mask_setting  = '1;
        items_sent    = 0;
        errors        = 0;
        phases        = 0;
        n_answered    = 0;
        n_kept        = 0;
        n_dropped     = 0;
        quiet_cycles  = 0;
        rx_hold       = 0;
        rx_gap        = 0;
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        foreach (query_vec[f])
            query_vec[f] = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_store_full();
        test_backpressure();
        test_settings_sweep();
        test_full_rate_tail();

        wait_drained();
        if (pending_answers.size() != 0) begin
            $error("%0d results never arrived", pending_answers.size());
            errors++;
        end
        $display("Covered %0d stream items under %0d register settings, incl. store overflow",
                 items_sent, phases);
        $display("and a long output stall: %0d queries, %0d samples kept, %0d dropped.",
                 n_answered, n_kept, n_dropped);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: knn_binary_classifier_core.f
+incdir+rtl/core
rtl/core/knn_pkg.sv
rtl/core/knn_ram.sv
rtl/core/knn_cell.sv
rtl/core/knn_dist.sv
rtl/core/knn_binary_classifier_core.sv
dv/tb_knn_binary_classifier_core.sv
